// ----- sv/kmst_pkg.sv -----
// shared constants and control structs for the kruskal spanning tree core
// no dependencies; used by every module of the block
package kmst_pkg;

   localparam int VERT_W           = 6;
   localparam int WEIGHT_W         = 16;
   localparam int TOTAL_W          = 22;
   localparam int EDGE_W           = WEIGHT_W + 2 * VERT_W;
   localparam int REQ_DATA_W       = 32;
   localparam int RSP_DATA_W       = 56;
   localparam int RSP_PAD_W        = RSP_DATA_W - TOTAL_W - EDGE_W;
   localparam int DEF_MAX_EDGES    = 64;
   localparam int DEF_NUM_VERTICES = 64;

   typedef struct packed {
      logic start;
      logic first;
   } sel_cmd_type;

   typedef struct packed {
      logic                done;
      logic                found;
      logic [WEIGHT_W-1:0] weight;
      logic [VERT_W-1:0]   vert_a;
      logic [VERT_W-1:0]   vert_b;
   } sel_res_type;

   typedef struct packed {
      logic              clear;
      logic              join_req;
      logic [VERT_W-1:0] vert_a;
      logic [VERT_W-1:0] vert_b;
   } uf_cmd_type;

   typedef struct packed {
      logic done;
      logic merged;
   } uf_res_type;

endpackage

// ----- sv/kmst_edge_sel.sv -----
// edge store and ordered selector: each pass scans the stored edges and
// returns the smallest {weight, index} key above the previous pick; uses kmst_pkg
module kmst_edge_sel #(
   parameter int MAX_EDGES = kmst_pkg::DEF_MAX_EDGES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_EDGES)-1:0]      wr_addr,
   input  logic [kmst_pkg::EDGE_W-1:0]       wr_data,
   input  logic [$clog2(MAX_EDGES+1)-1:0]    count,
   input  kmst_pkg::sel_cmd_type             cmd,
   output kmst_pkg::sel_res_type             res
);
   import kmst_pkg::*;

   localparam int IW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int KW = WEIGHT_W + IW;

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   logic [EDGE_W-1:0] mem [MAX_EDGES];
   logic [EDGE_W-1:0] rdata_ff;

   state_type         st_ff, st_in;
   logic [CW-1:0]     rd_addr_ff, rd_addr_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pend_idx_ff, pend_idx_in;
   logic              have_best_ff, have_best_in;
   logic [KW-1:0]     best_key_ff, best_key_in;
   logic [VERT_W-1:0] best_a_ff, best_a_in;
   logic [VERT_W-1:0] best_b_ff, best_b_in;
   logic              have_last_ff, have_last_in;
   logic [KW-1:0]     last_key_ff, last_key_in;
   logic              done_ff, done_in;
   logic              rd_en;
   logic              better;
   logic [KW-1:0]     cand_key;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr_ff[IW-1:0]];
   end

   always_comb begin
      cand_key = {rdata_ff[EDGE_W-1:2*VERT_W], pend_idx_ff};
      better   = pend_ff && (!have_last_ff || cand_key > last_key_ff)
                 && (!have_best_ff || cand_key < best_key_ff);
      rd_en    = rd_addr_ff < count;

      st_in        = st_ff;
      rd_addr_in   = rd_addr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      have_best_in = have_best_ff;
      best_key_in  = best_key_ff;
      best_a_in    = best_a_ff;
      best_b_in    = best_b_ff;
      have_last_in = have_last_ff;
      last_key_in  = last_key_ff;
      done_in      = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (cmd.start) begin
               rd_addr_in   = '0;
               pend_in      = 1'b0;
               have_best_in = 1'b0;
               if (cmd.first) begin
                  have_last_in = 1'b0;
               end
               st_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // the read address runs ahead of the compare by the registered read data
            if (rd_en) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_addr_ff[IW-1:0];
               rd_addr_in  = rd_addr_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (better) begin
               have_best_in = 1'b1;
               best_key_in  = cand_key;
               best_a_in    = rdata_ff[2*VERT_W-1:VERT_W];
               best_b_in    = rdata_ff[VERT_W-1:0];
            end
            if (!rd_en && !pend_ff) begin
               done_in = 1'b1;
               st_in   = S_IDLE;
               if (have_best_ff) begin
                  have_last_in = 1'b1;
                  last_key_in  = best_key_ff;
               end
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         pend_ff      <= 1'b0;
         have_best_ff <= 1'b0;
         have_last_ff <= 1'b0;
         done_ff      <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         st_ff        <= st_in;
         pend_ff      <= pend_in;
         have_best_ff <= have_best_in;
         have_last_ff <= have_last_in;
         done_ff      <= done_in;
         rd_addr_ff   <= rd_addr_in;
      end
      pend_idx_ff <= pend_idx_in;
      best_key_ff <= best_key_in;
      best_a_ff   <= best_a_in;
      best_b_ff   <= best_b_in;
      last_key_ff <= last_key_in;
   end

   assign res.done   = done_ff;
   assign res.found  = have_best_ff;
   assign res.weight = best_key_ff[KW-1:IW];
   assign res.vert_a = best_a_ff;
   assign res.vert_b = best_b_ff;

endmodule

// ----- sv/kmst_union_find.sv -----
// union-find parent table with identity reload, root walk and merge
// uses kmst_pkg for the command and status structs
module kmst_union_find #(
   parameter int NUM_VERTICES = kmst_pkg::DEF_NUM_VERTICES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kmst_pkg::uf_cmd_type cmd,
   output kmst_pkg::uf_res_type res
);
   import kmst_pkg::*;

   localparam int PW = $clog2(NUM_VERTICES);

   typedef enum logic [2:0] {
      U_IDLE, U_CLR, U_FA_RD, U_FA_CHK, U_FB_RD, U_FB_CHK, U_MERGE
   } state_type;

   logic [PW-1:0] mem [NUM_VERTICES];

   state_type     st_ff, st_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [PW-1:0] ra_ff, ra_in;
   logic [PW-1:0] b_ff, b_in;
   logic [PW-1:0] pdata_ff;
   logic          done_ff, done_in;
   logic          merged_ff, merged_in;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [PW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      pdata_ff <= mem[cur_ff];
   end

   always_comb begin
      st_in     = st_ff;
      cur_in    = cur_ff;
      ra_in     = ra_ff;
      b_in      = b_ff;
      done_in   = 1'b0;
      merged_in = merged_ff;
      wr_en     = 1'b0;
      wr_addr   = cur_ff;
      wr_data   = cur_ff;

      case (st_ff)
         U_IDLE: begin
            if (cmd.clear) begin
               cur_in = '0;
               st_in  = U_CLR;
            end else if (cmd.join_req) begin
               cur_in = PW'(cmd.vert_a);
               b_in   = PW'(cmd.vert_b);
               st_in  = U_FA_RD;
            end
         end
         U_CLR: begin
            wr_en = 1'b1;
            if (cur_ff == PW'(NUM_VERTICES - 1)) begin
               done_in = 1'b1;
               st_in   = U_IDLE;
            end else begin
               cur_in = cur_ff + PW'(1);
            end
         end
         U_FA_RD: begin
            st_in = U_FA_CHK;
         end
         U_FA_CHK: begin
            if (pdata_ff == cur_ff) begin
               ra_in  = cur_ff;
               cur_in = b_ff;
               st_in  = U_FB_RD;
            end else begin
               cur_in = pdata_ff;
               st_in  = U_FA_RD;
            end
         end
         U_FB_RD: begin
            st_in = U_FB_CHK;
         end
         U_FB_CHK: begin
            if (pdata_ff == cur_ff) begin
               st_in = U_MERGE;
            end else begin
               cur_in = pdata_ff;
               st_in  = U_FB_RD;
            end
         end
         U_MERGE: begin
            // cur holds the root of the second endpoint
            merged_in = ra_ff != cur_ff;
            wr_en     = ra_ff != cur_ff;
            wr_addr   = ra_ff;
            wr_data   = cur_ff;
            done_in   = 1'b1;
            st_in     = U_IDLE;
         end
         default: begin
            st_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= U_IDLE;
         done_ff   <= 1'b0;
         merged_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         done_ff   <= done_in;
         merged_ff <= merged_in;
      end
      cur_ff <= cur_in;
      ra_ff  <= ra_in;
      b_ff   <= b_in;
   end

   assign res.done   = done_ff;
   assign res.merged = merged_ff;

endmodule

// ----- sv/kruskal_mst_union_find_core.sv -----
// channel   dir  handshake            payload
// req_      in   req_tvalid/tready    tdata: edge, tlast: last edge of the graph
// rsp_      out  rsp_tvalid/tready    tdata: tree edge and total, tuser: is_total,
//                                     tlast: final item of the run
// edges load one per cycle. after the last edge the core is busy: the parent table is
// reloaded with the identity, then each scan step walks the edge store once and each
// union walks both endpoints to their roots, reading and checking one parent per hop,
// then merges. each memory has a single read port.
// reset is synchronous; a stalled rsp holds the core until the transaction is taken.
// top level: kmst_edge_sel, kmst_union_find and kmst_pkg
module kruskal_mst_union_find_core #(
   parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES,
   parameter int NUM_VERTICES = kmst_pkg::DEF_NUM_VERTICES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // first_vertex[5:0], second_vertex[11:6], weight[27:12], zero fill
   input  logic [kmst_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tree_first_vertex[5:0], tree_second_vertex[11:6], tree_weight[27:12],
   // total_weight[49:28], zero fill
   output logic [kmst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_total
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import kmst_pkg::*;

   localparam int IW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);

   typedef enum logic [2:0] {T_LOAD, T_CLEAR, T_SELECT, T_UNION, T_EMIT} state_type;

   state_type             st_ff, st_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [WEIGHT_W-1:0]   w_ff, w_in;
   logic [VERT_W-1:0]     a_ff, a_in;
   logic [VERT_W-1:0]     b_ff, b_in;
   sel_cmd_type           sel_cmd_ff, sel_cmd_in;
   uf_cmd_type            uf_cmd_ff, uf_cmd_in;
   sel_res_type           sel_res;
   uf_res_type            uf_res;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  req_acc;
   logic                  store_en;
   logic                  out_of_range;

   assign req_tready = st_ff == T_LOAD;
   assign req_acc    = req_tvalid && req_tready;
   assign store_en   = req_acc && (count_ff < CW'(MAX_EDGES));

   kmst_edge_sel #(.MAX_EDGES(MAX_EDGES)) u_sel (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ({req_tdata[EDGE_W-1:2*VERT_W], req_tdata[VERT_W-1:0],
                 req_tdata[2*VERT_W-1:VERT_W]}),
      .count   (count_ff),
      .cmd     (sel_cmd_ff),
      .res     (sel_res)
   );

   kmst_union_find #(.NUM_VERTICES(NUM_VERTICES)) u_uf (
      .clock (clock),
      .reset (reset),
      .cmd   (uf_cmd_ff),
      .res   (uf_res)
   );

   assign out_of_range = (32'(sel_res.vert_a) >= 32'(NUM_VERTICES))
                         || (32'(sel_res.vert_b) >= 32'(NUM_VERTICES));

   always_comb begin
      st_in        = st_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      sel_cmd_in   = '0;
      uf_cmd_in    = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      case (st_ff)
         T_LOAD: begin
            if (req_acc) begin
               if (store_en) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_tlast) begin
                  uf_cmd_in.clear = 1'b1;
                  total_in        = '0;
                  st_in           = T_CLEAR;
               end
            end
         end
         T_CLEAR: begin
            if (uf_res.done) begin
               sel_cmd_in.start = 1'b1;
               sel_cmd_in.first = 1'b1;
               st_in            = T_SELECT;
            end
         end
         T_SELECT: begin
            if (sel_res.done) begin
               if (!sel_res.found) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {{RSP_PAD_W{1'b0}}, total_ff, {EDGE_W{1'b0}}};
                  rsp_user_in  = 1'b1;
                  rsp_last_in  = 1'b1;
                  st_in        = T_EMIT;
               end else if (out_of_range) begin
                  sel_cmd_in.start = 1'b1;
               end else begin
                  uf_cmd_in.join_req = 1'b1;
                  uf_cmd_in.vert_a   = sel_res.vert_a;
                  uf_cmd_in.vert_b   = sel_res.vert_b;
                  w_in               = sel_res.weight;
                  a_in               = sel_res.vert_a;
                  b_in               = sel_res.vert_b;
                  st_in              = T_UNION;
               end
            end
         end
         T_UNION: begin
            if (uf_res.done) begin
               if (uf_res.merged) begin
                  total_in     = total_ff + TOTAL_W'(w_ff);
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {{RSP_PAD_W{1'b0}}, {TOTAL_W{1'b0}}, w_ff, b_ff, a_ff};
                  rsp_user_in  = 1'b0;
                  rsp_last_in  = 1'b0;
                  st_in        = T_EMIT;
               end else begin
                  sel_cmd_in.start = 1'b1;
                  st_in            = T_SELECT;
               end
            end
         end
         T_EMIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_user_ff) begin
                  count_in = '0;
                  total_in = '0;
                  st_in    = T_LOAD;
               end else begin
                  sel_cmd_in.start = 1'b1;
                  st_in            = T_SELECT;
               end
            end
         end
         default: begin
            st_in = T_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_LOAD;
         count_ff     <= '0;
         total_ff     <= '0;
         sel_cmd_ff   <= '0;
         uf_cmd_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         sel_cmd_ff   <= sel_cmd_in;
         uf_cmd_ff    <= uf_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff        <= w_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // loading and result output never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("req ready while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   // after the total transaction the core returns to loading
   a_total_reload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser |=> req_tready && count_ff == '0)
      else $error("core not back to load after total");

   a_edge_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tlast && rsp_tdata[RSP_DATA_W-1:EDGE_W] == '0)
      else $error("tree edge item carries total fields");

endmodule
